// ===== rtl/core/pfpu_pkg.sv =====
// ----------------------------------------------------------------------------
// pfpu_pkg: shared types and constants of the pipeline fault priority unit
// Field widths, operation and kind codes, vector addresses, beat payloads.
// ----------------------------------------------------------------------------
package pfpu_pkg;

   localparam int STAGE_COUNT_DEFAULT = 5;
   localparam int STAGE_W             = 3;

   // operation codes (func field)
   localparam logic [1:0] FUNC_QUEUE_EXC   = 2'd0;
   localparam logic [1:0] FUNC_QUEUE_LOCK  = 2'd1;
   localparam logic [1:0] FUNC_HANDLE_EXC  = 2'd2;
   localparam logic [1:0] FUNC_HANDLE_LOCK = 2'd3;

   // exception kinds
   localparam logic [1:0] EXC_OTHER = 2'd0;
   localparam logic [1:0] EXC_RESET = 2'd1;
   localparam logic [1:0] EXC_CPU   = 2'd2;
   localparam logic [1:0] EXC_INT   = 2'd3;

   // interlock kinds
   localparam logic [1:0] LOCK_OTHER   = 2'd0;
   localparam logic [1:0] LOCK_ICACHE  = 2'd1;
   localparam logic [1:0] LOCK_CACHEOP = 2'd2;

   // reported actions
   localparam logic [1:0] ACT_NONE       = 2'd0;
   localparam logic [1:0] ACT_ENTRY      = 2'd1;
   localparam logic [1:0] ACT_HARD_RESET = 2'd2;
   localparam logic [1:0] ACT_SOFT_RESET = 2'd3;

   // vectors, already less 4
   localparam logic [63:0] VEC_GENERAL_BEV = 64'hFFFF_FFFF_BFC0_0200 - 64'd4;
   localparam logic [63:0] VEC_GENERAL     = 64'hFFFF_FFFF_8000_0180 - 64'd4;
   localparam logic [63:0] VEC_RESET       = 64'hFFFF_FFFF_BFC0_0000 - 64'd4;

   localparam logic [5:0] IL_STALL  = 6'd54;
   localparam logic [4:0] CODE_CPU  = 5'd11;
   localparam logic [4:0] CODE_INT  = 5'd0;

   typedef struct packed {
      logic [1:0]         func;
      logic [1:0]         fault_kind;
      logic [STAGE_W-1:0] stage;
      logic [63:0]        fault_pc;
      logic               in_branch_delay;
      logic [1:0]         cause_data;
      logic [31:0]        interlock_data;
      logic               status_exl;
      logic               status_bev;
   } req_payload_type;

   typedef struct packed {
      logic        faulting;
      logic [1:0]  action;
      logic [63:0] new_pc;
      logic [4:0]  exc_code;
      logic [1:0]  ce_value;
      logic        epc_write;
      logic [63:0] epc_value;
      logic        branch_delay;
      logic        fill_request;
      logic [31:0] fill_address;
      logic [5:0]  stall_cycles;
   } rsp_payload_type;

endpackage

// ===== rtl/core/pfpu_req_if.sv =====
// ----------------------------------------------------------------------------
// pfpu_req_if: request channel of the fault priority unit
// Valid/ready channel carrying one fault request beat.
// ----------------------------------------------------------------------------
interface pfpu_req_if;
   logic                      valid;
   logic                      ready;
   pfpu_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/pfpu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pfpu_rsp_if: response channel of the fault priority unit
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface pfpu_rsp_if;
   logic                      valid;
   logic                      ready;
   pfpu_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/pfpu_slots.sv =====
// ----------------------------------------------------------------------------
// pfpu_slots: pending exception and interlock slots
// Holds both slots, resolves stage priority and forms the result of one beat.
// ----------------------------------------------------------------------------
module pfpu_slots #(
   parameter int STAGE_COUNT = pfpu_pkg::STAGE_COUNT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  pfpu_pkg::req_payload_type item,
   output pfpu_pkg::rsp_payload_type result
);
   import pfpu_pkg::*;

   localparam logic [STAGE_W:0] STAGE_LIMIT = (STAGE_W + 1)'(STAGE_COUNT);

   logic [STAGE_W-1:0] exc_stage_ff, exc_stage_in;
   logic [1:0]         exc_kind_ff, exc_kind_in;
   logic [63:0]        exc_pc_ff, exc_pc_in;
   logic               exc_delay_ff, exc_delay_in;
   logic [1:0]         exc_cause_ff, exc_cause_in;
   logic [STAGE_W-1:0] lock_stage_ff, lock_stage_in;
   logic [1:0]         lock_kind_ff, lock_kind_in;
   logic [31:0]        lock_addr_ff, lock_addr_in;
   logic               pending_ff, pending_in;
   logic               stage_ok;

   assign stage_ok = ({1'b0, item.stage} <= STAGE_LIMIT);

   always_comb begin
      exc_stage_in  = exc_stage_ff;
      exc_kind_in   = exc_kind_ff;
      exc_pc_in     = exc_pc_ff;
      exc_delay_in  = exc_delay_ff;
      exc_cause_in  = exc_cause_ff;
      lock_stage_in = lock_stage_ff;
      lock_kind_in  = lock_kind_ff;
      lock_addr_in  = lock_addr_ff;
      pending_in    = pending_ff;
      result        = '0;

      unique case (item.func)
         FUNC_QUEUE_EXC: begin
            if (stage_ok && (item.stage > exc_stage_ff)) begin
               exc_stage_in = item.stage;
               exc_kind_in  = item.fault_kind;
               exc_pc_in    = item.fault_pc;
               exc_delay_in = item.in_branch_delay;
               exc_cause_in = item.cause_data;
               pending_in   = 1'b1;
            end
         end
         FUNC_QUEUE_LOCK: begin
            if (stage_ok && (item.stage > lock_stage_ff)) begin
               lock_stage_in       = item.stage;
               lock_kind_in        = item.fault_kind;
               lock_addr_in        = item.interlock_data;
               pending_in          = 1'b1;
               result.stall_cycles = IL_STALL;
            end
         end
         FUNC_HANDLE_EXC: begin
            if (exc_stage_ff != '0) begin
               unique case (exc_kind_ff)
                  EXC_RESET: begin
                     result.action = (exc_cause_ff != 2'd0) ? ACT_SOFT_RESET
                                                            : ACT_HARD_RESET;
                     result.new_pc = VEC_RESET;
                  end
                  EXC_CPU, EXC_INT: begin
                     result.action   = ACT_ENTRY;
                     result.exc_code = (exc_kind_ff == EXC_CPU) ? CODE_CPU : CODE_INT;
                     result.ce_value = exc_cause_ff;
                     if (!item.status_exl) begin
                        result.epc_write    = 1'b1;
                        result.branch_delay = exc_delay_ff;
                        result.epc_value    = exc_delay_ff ? (exc_pc_ff - 64'd4)
                                                           : exc_pc_ff;
                     end
                     result.new_pc = item.status_bev ? VEC_GENERAL_BEV : VEC_GENERAL;
                  end
                  default: ;
               endcase
            end
            exc_stage_in  = '0;
            exc_kind_in   = EXC_OTHER;
            lock_stage_in = '0;
            lock_kind_in  = LOCK_OTHER;
            pending_in    = 1'b0;
         end
         FUNC_HANDLE_LOCK: begin
            if ((lock_stage_ff != '0) &&
                ((lock_kind_ff == LOCK_ICACHE) || (lock_kind_ff == LOCK_CACHEOP))) begin
               result.fill_request = 1'b1;
               result.fill_address = lock_addr_ff;
            end
            pending_in    = (exc_stage_ff != '0);
            lock_stage_in = '0;
            lock_kind_in  = LOCK_OTHER;
         end
         default: ;
      endcase

      result.faulting = pending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exc_stage_ff  <= '0;
         exc_kind_ff   <= EXC_OTHER;
         lock_stage_ff <= '0;
         lock_kind_ff  <= LOCK_OTHER;
         pending_ff    <= 1'b0;
      end else if (fire) begin
         exc_stage_ff  <= exc_stage_in;
         exc_kind_ff   <= exc_kind_in;
         lock_stage_ff <= lock_stage_in;
         lock_kind_ff  <= lock_kind_in;
         pending_ff    <= pending_in;
      end
   end

   // slot payload is only read while its stage is nonzero
   always_ff @(posedge clock) begin
      if (fire) begin
         exc_pc_ff    <= exc_pc_in;
         exc_delay_ff <= exc_delay_in;
         exc_cause_ff <= exc_cause_in;
         lock_addr_ff <= lock_addr_in;
      end
   end

endmodule

// ===== rtl/core/pipeline_fault_priority_unit.sv =====
// ----------------------------------------------------------------------------
// pipeline_fault_priority_unit: exception and interlock priority for a pipeline
// Input register, slot logic, result register; one request beat per clock unless rsp_chan stalls.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request beat: queue an exception, queue an
//   interlock, handle the pending exception or handle the pending interlock.
//   Every request beat yields exactly one beat on rsp_chan, in order.
//   An accepted beat sits in the input register, the slot logic evaluates
//   it against the pending slots and the result is loaded into the result
//   register and offered on rsp_chan. Throughput is one beat per clock
//   unless rsp_chan stalls; the slots update in the same cycle the result
//   register loads, so the next beat sees them right away.
//   When the receiver stalls, the result register holds its beat and the
//   input register holds one more; req_chan.ready drops only when both
//   are full. Nothing is dropped or repeated.
//   Reset (synchronous, active high) empties both registers and clears both
//   slots to "nothing pending".
// ----------------------------------------------------------------------------
module pipeline_fault_priority_unit #(
   parameter int STAGE_COUNT = pfpu_pkg::STAGE_COUNT_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   pfpu_req_if.sink   req_chan,
   pfpu_rsp_if.source rsp_chan
);
   import pfpu_pkg::*;

   // input register
   logic            req_valid_ff, req_valid_in;
   req_payload_type req_item_ff;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_item_ff;
   rsp_payload_type slot_result;

   logic out_open;   // result register can take a beat this cycle
   logic fire;       // input beat moves through the slot logic
   logic req_take;

   assign out_open = !rsp_valid_ff || rsp_chan.ready;
   assign fire     = req_valid_ff && out_open;
   assign req_chan.ready = !req_valid_ff || out_open;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (fire) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input payload starts known so the slot decode never sees an unknown op
   always_ff @(posedge clock) begin
      if (reset) begin
         req_item_ff <= '0;
      end else if (req_take) begin
         req_item_ff <= req_chan.payload;
      end
      if (fire) begin
         rsp_item_ff <= slot_result;
      end
   end

   pfpu_slots #(
      .STAGE_COUNT(STAGE_COUNT)
   ) u_slots (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (req_item_ff),
      .result(slot_result)
   );

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

   // ---------------------------------------------------------------- checks
   // an accepted interlock always leaves something pending
   a_stall_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.payload.stall_cycles != 6'd0))
         |-> rsp_chan.payload.faulting)
      else $error("stall reported with nothing pending");

   // handling an exception flushes both slots
   a_action_flush: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.payload.action != ACT_NONE))
         |-> !rsp_chan.payload.faulting)
      else $error("slots not flushed after exception action");

   // EPC is only written on a regular exception entry
   a_epc_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.epc_write)
         |-> (rsp_chan.payload.action == ACT_ENTRY))
      else $error("EPC write outside exception entry");

   // a beat that passes the slot logic shows up as a result next cycle
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_chan.valid)
      else $error("evaluated beat missing from result register");

endmodule

// ===== tb/tb_pipeline_fault_priority_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pipeline_fault_priority_unit: self-checking bench for the fault unit
// A table of directed fault beats comes first, then 510 random ones.
// Each accepted request goes through a slot predictor and every response is
// checked field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_pipeline_fault_priority_unit;
   import pfpu_pkg::*;

   localparam int STAGE_COUNT = 5;

   // Interlock kind with no name in the package: no refill on handling.
   localparam logic [1:0] LOCK_SPARE = 2'd3;

   // Entry points as the handler sees them (vector less 4).
   localparam logic [63:0] ENTRY_BEV   = 64'hFFFF_FFFF_BFC0_0200 - 64'd4;
   localparam logic [63:0] ENTRY_GEN   = 64'hFFFF_FFFF_8000_0180 - 64'd4;
   localparam logic [63:0] ENTRY_RESET = 64'hFFFF_FFFF_BFC0_0000 - 64'd4;

   localparam int RANDOM_PER_PHASE = 170;
   localparam int HOLD_OFF_CYCLES  = 80;
   localparam int DRAIN_CYCLES     = 8;

   logic clock;
   logic reset;

   pfpu_req_if req_chan ();
   pfpu_rsp_if rsp_chan ();

   pipeline_fault_priority_unit #(
      .STAGE_COUNT (STAGE_COUNT)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Pending exception and interlock slots as the predictor sees them.
   typedef struct {
      logic [2:0]  exc_stage;
      logic [1:0]  exc_kind;
      logic [63:0] exc_pc;
      logic        exc_in_delay;
      logic [1:0]  exc_cause;
      logic [2:0]  lock_stage;
      logic [1:0]  lock_kind;
      logic [31:0] lock_address;
      logic        pending;
   } fault_slots_type;

   // One row of the directed table. When typed is set the response is
   // written out by hand; otherwise the predictor supplies it.
   typedef struct {
      req_payload_type req;
      bit              typed;
      rsp_payload_type rsp;
   } directed_row_type;

   fault_slots_type  slots;
   rsp_payload_type  expected_responses[$];
   directed_row_type directed_rows[$];

   int  mismatch_count = 0;
   int  rsp_beats      = 0;
   int  tx_idle_pct    = 0;
   int  rx_idle_pct    = 0;
   bit  want_hold_off  = 0;
   bit  hold_off_done  = 0;
   int  hold_left      = 0;

   // 2 ns period
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Slot predictor: takes one accepted request beat, updates the slots and
   // returns the response beat it must produce.
   // ------------------------------------------------------------------------
   function automatic rsp_payload_type predict_fault_response(input req_payload_type r);
      rsp_payload_type rsp;
      rsp = '0;
      case (r.func)
         FUNC_QUEUE_EXC: begin
            // only a strictly later, in-range stage takes the slot
            if (r.stage <= STAGE_COUNT && r.stage > slots.exc_stage) begin
               slots.exc_stage    = r.stage;
               slots.exc_kind     = r.fault_kind;
               slots.exc_pc       = r.fault_pc;
               slots.exc_in_delay = r.in_branch_delay;
               slots.exc_cause    = r.cause_data;
               slots.pending      = 1'b1;
            end
         end
         FUNC_QUEUE_LOCK: begin
            if (r.stage <= STAGE_COUNT && r.stage > slots.lock_stage) begin
               slots.lock_stage   = r.stage;
               slots.lock_kind    = r.fault_kind;
               slots.lock_address = r.interlock_data;
               slots.pending      = 1'b1;
               rsp.stall_cycles   = IL_STALL;
            end
         end
         FUNC_HANDLE_EXC: begin
            if (slots.exc_stage != 3'd0) begin
               if (slots.exc_kind == EXC_RESET) begin
                  rsp.action = (slots.exc_cause != 2'd0) ? ACT_SOFT_RESET : ACT_HARD_RESET;
                  rsp.new_pc = ENTRY_RESET;
               end else if (slots.exc_kind == EXC_CPU || slots.exc_kind == EXC_INT) begin
                  rsp.action   = ACT_ENTRY;
                  rsp.exc_code = (slots.exc_kind == EXC_CPU) ? CODE_CPU : CODE_INT;
                  rsp.ce_value = slots.exc_cause;
                  // EPC and BD are written only at exception level zero
                  if (!r.status_exl) begin
                     rsp.epc_write    = 1'b1;
                     rsp.branch_delay = slots.exc_in_delay;
                     rsp.epc_value    = slots.exc_in_delay ? slots.exc_pc - 64'd4
                                                           : slots.exc_pc;
                  end
                  rsp.new_pc = r.status_bev ? ENTRY_BEV : ENTRY_GEN;
               end
            end
            // both slots flush regardless of what was pending
            slots.exc_stage  = 3'd0;
            slots.exc_kind   = EXC_OTHER;
            slots.lock_stage = 3'd0;
            slots.lock_kind  = LOCK_OTHER;
            slots.pending    = 1'b0;
         end
         FUNC_HANDLE_LOCK: begin
            if (slots.lock_stage != 3'd0 &&
                (slots.lock_kind == LOCK_ICACHE || slots.lock_kind == LOCK_CACHEOP)) begin
               rsp.fill_request = 1'b1;
               rsp.fill_address = slots.lock_address;
            end
            slots.pending    = (slots.exc_stage != 3'd0);
            slots.lock_stage = 3'd0;
            slots.lock_kind  = LOCK_OTHER;
         end
      endcase
      rsp.faulting = slots.pending;
      return rsp;
   endfunction

   function automatic req_payload_type mk_req(
      input logic [1:0] func, input logic [1:0] kind, input logic [2:0] stage,
      input logic [63:0] pc, input logic in_delay, input logic [1:0] cause,
      input logic [31:0] address, input logic exl, input logic bev);
      req_payload_type r;
      r.func            = func;
      r.fault_kind      = kind;
      r.stage           = stage;
      r.fault_pc        = pc;
      r.in_branch_delay = in_delay;
      r.cause_data      = cause;
      r.interlock_data  = address;
      r.status_exl      = exl;
      r.status_bev      = bev;
      return r;
   endfunction

   function automatic rsp_payload_type mk_rsp(
      input logic faulting, input logic [1:0] action, input logic [63:0] new_pc,
      input logic [4:0] code, input logic [1:0] ce, input logic epc_write,
      input logic [63:0] epc, input logic bd, input logic fill,
      input logic [31:0] fill_address, input logic [5:0] stall);
      rsp_payload_type p;
      p.faulting     = faulting;
      p.action       = action;
      p.new_pc       = new_pc;
      p.exc_code     = code;
      p.ce_value     = ce;
      p.epc_write    = epc_write;
      p.epc_value    = epc;
      p.branch_delay = bd;
      p.fill_request = fill;
      p.fill_address = fill_address;
      p.stall_cycles = stall;
      return p;
   endfunction

   // Random beat: mostly in-range stages, occasionally zero or past the end.
   function automatic req_payload_type random_fault_request();
      req_payload_type r;
      int              pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      r.func = FUNC_QUEUE_EXC;
      else if (pick < 60) r.func = FUNC_QUEUE_LOCK;
      else if (pick < 80) r.func = FUNC_HANDLE_EXC;
      else                r.func = FUNC_HANDLE_LOCK;
      r.fault_kind      = 2'($urandom_range(0, 3));
      r.stage           = ($urandom_range(0, 19) < 17) ? 3'($urandom_range(1, STAGE_COUNT))
                                                       : 3'($urandom_range(0, 7));
      r.fault_pc        = {$urandom, $urandom};
      r.in_branch_delay = 1'($urandom_range(0, 1));
      r.cause_data      = 2'($urandom_range(0, 3));
      r.interlock_data  = $urandom;
      r.status_exl      = 1'($urandom_range(0, 1));
      r.status_bev      = 1'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: response %0d %s: got %h, expected %h",
               $realtime, rsp_beats, what, got, want);
      mismatch_count++;
   endtask

   // Offer one beat, idling first with the current sender probability.
   // valid is set at most once per edge, so back-to-back beats keep it high.
   task automatic send_beat(input req_payload_type r);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random back-pressure, plus one long hold-off that keeps ready
   // low while the sender keeps offering, so the unit fills and stalls.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (want_hold_off && !hold_off_done) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= HOLD_OFF_CYCLES;
         hold_off_done  <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Response checker: oldest expectation against each accepted beat.
   always @(posedge clock) begin
      rsp_payload_type got;
      rsp_payload_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got = rsp_chan.payload;
         if (expected_responses.size() == 0) begin
            report_mismatch("beat with nothing expected", got.new_pc, 64'd0);
         end else begin
            want = expected_responses.pop_front();
            if (got.faulting !== want.faulting)
               report_mismatch("faulting", 64'(got.faulting), 64'(want.faulting));
            if (got.action !== want.action)
               report_mismatch("action", 64'(got.action), 64'(want.action));
            if (got.new_pc !== want.new_pc)
               report_mismatch("new_pc", got.new_pc, want.new_pc);
            if (got.exc_code !== want.exc_code)
               report_mismatch("exc_code", 64'(got.exc_code), 64'(want.exc_code));
            if (got.ce_value !== want.ce_value)
               report_mismatch("ce_value", 64'(got.ce_value), 64'(want.ce_value));
            if (got.epc_write !== want.epc_write)
               report_mismatch("epc_write", 64'(got.epc_write), 64'(want.epc_write));
            if (got.epc_value !== want.epc_value)
               report_mismatch("epc_value", got.epc_value, want.epc_value);
            if (got.branch_delay !== want.branch_delay)
               report_mismatch("branch_delay", 64'(got.branch_delay),
                               64'(want.branch_delay));
            if (got.fill_request !== want.fill_request)
               report_mismatch("fill_request", 64'(got.fill_request),
                               64'(want.fill_request));
            if (got.fill_address !== want.fill_address)
               report_mismatch("fill_address", 64'(got.fill_address),
                               64'(want.fill_address));
            if (got.stall_cycles !== want.stall_cycles)
               report_mismatch("stall_cycles", 64'(got.stall_cycles),
                               64'(want.stall_cycles));
         end
         rsp_beats++;
      end
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #400000;
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      rsp_payload_type idle_rsp;
      rsp_payload_type pend_rsp;
      rsp_payload_type want;

      reset            = 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      slots            = '{default: '0};

      idle_rsp = mk_rsp(0, ACT_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      pend_rsp = mk_rsp(1, ACT_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0);

      // handling with nothing pending, after reset
      directed_rows.push_back('{mk_req(FUNC_HANDLE_EXC, EXC_CPU, 3'd5, 64'd0, 0, 0, 0, 0, 0),
                                1, idle_rsp});
      directed_rows.push_back('{mk_req(FUNC_HANDLE_LOCK, LOCK_ICACHE, 3'd5, 64'd0, 0, 0,
                                       32'hFFFF_FFFF, 0, 0), 1, idle_rsp});
      // stage zero and stage past the last one never enter a slot
      directed_rows.push_back('{mk_req(FUNC_QUEUE_EXC, EXC_CPU, 3'd0, 64'd4, 0, 0, 0, 0, 0),
                                1, idle_rsp});
      directed_rows.push_back('{mk_req(FUNC_QUEUE_EXC, EXC_CPU, 3'd7, 64'd4, 0, 0, 0, 0, 0),
                                1, idle_rsp});
      // coprocessor unusable in a delay slot at all-ones pc
      directed_rows.push_back('{mk_req(FUNC_QUEUE_EXC, EXC_CPU, 3'd3, '1, 1, 2'd3, 0, 0, 0),
                                1, pend_rsp});
      // equal and lower stages are ignored
      directed_rows.push_back('{mk_req(FUNC_QUEUE_EXC, EXC_INT, 3'd3, 64'd0, 0, 0, 0, 0, 0),
                                1, pend_rsp});
      directed_rows.push_back('{mk_req(FUNC_QUEUE_EXC, EXC_INT, 3'd2, 64'd0, 0, 0, 0, 0, 0),
                                1, pend_rsp});
      directed_rows.push_back('{mk_req(FUNC_HANDLE_EXC, EXC_OTHER, 3'd0, 64'd0, 0, 0, 0, 0, 1),
                                1, mk_rsp(0, ACT_ENTRY, 64'hFFFF_FFFF_BFC0_01FC, CODE_CPU,
                                          2'd3, 1, 64'hFFFF_FFFF_FFFF_FFFB, 1, 0, 0, 0)});
      // interlocks: accepted one stalls, repeats and out-of-range do not
      directed_rows.push_back('{mk_req(FUNC_QUEUE_LOCK, LOCK_ICACHE, 3'd5, 64'd0, 0, 0,
                                       32'hFFFF_FFFF, 0, 0),
                                1, mk_rsp(1, ACT_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 6'd54)});
      directed_rows.push_back('{mk_req(FUNC_QUEUE_LOCK, LOCK_CACHEOP, 3'd5, 64'd0, 0, 0, 0, 0, 0),
                                1, pend_rsp});
      directed_rows.push_back('{mk_req(FUNC_QUEUE_LOCK, LOCK_CACHEOP, 3'd6, 64'd0, 0, 0, 0, 0, 0),
                                1, pend_rsp});
      directed_rows.push_back('{mk_req(FUNC_HANDLE_LOCK, LOCK_OTHER, 3'd0, 64'd0, 0, 0, 0, 0, 0),
                                1, mk_rsp(0, ACT_NONE, 0, 0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF, 0)});
      // interrupt with exception level set: no EPC write, general vector
      directed_rows.push_back('{mk_req(FUNC_QUEUE_EXC, EXC_INT, 3'd5, 64'd0, 1, 2'd2, 0, 0, 0),
                                0, '0});
      directed_rows.push_back('{mk_req(FUNC_HANDLE_EXC, EXC_OTHER, 3'd0, 64'd0, 0, 0, 0, 1, 0),
                                1, mk_rsp(0, ACT_ENTRY, 64'hFFFF_FFFF_8000_017C, CODE_INT,
                                          2'd2, 0, 0, 0, 0, 0, 0)});
      // hard reset, with a cache-op refill handled in between
      directed_rows.push_back('{mk_req(FUNC_QUEUE_EXC, EXC_RESET, 3'd1, 64'h80, 0, 0, 0, 0, 0),
                                0, '0});
      directed_rows.push_back('{mk_req(FUNC_QUEUE_LOCK, LOCK_CACHEOP, 3'd1, 64'd0, 0, 0,
                                       32'h1234_5678, 0, 0), 0, '0});
      directed_rows.push_back('{mk_req(FUNC_HANDLE_LOCK, LOCK_OTHER, 3'd0, 64'd0, 0, 0, 0, 0, 0),
                                1, mk_rsp(1, ACT_NONE, 0, 0, 0, 0, 0, 0, 1, 32'h1234_5678, 0)});
      directed_rows.push_back('{mk_req(FUNC_HANDLE_EXC, EXC_OTHER, 3'd0, 64'd0, 0, 0, 0, 0, 0),
                                1, mk_rsp(0, ACT_HARD_RESET, 64'hFFFF_FFFF_BFBF_FFFC,
                                          0, 0, 0, 0, 0, 0, 0, 0)});
      // soft reset ignores BEV
      directed_rows.push_back('{mk_req(FUNC_QUEUE_EXC, EXC_RESET, 3'd4, 64'h40, 1, 2'd1, 0, 0, 0),
                                0, '0});
      directed_rows.push_back('{mk_req(FUNC_HANDLE_EXC, EXC_OTHER, 3'd0, 64'd0, 0, 0, 0, 0, 1),
                                1, mk_rsp(0, ACT_SOFT_RESET, 64'hFFFF_FFFF_BFBF_FFFC,
                                          0, 0, 0, 0, 0, 0, 0, 0)});
      // unimplemented kinds: no action, no refill, but slots still clear
      directed_rows.push_back('{mk_req(FUNC_QUEUE_EXC, EXC_OTHER, 3'd2, 64'h1000, 0, 0, 0, 0, 0),
                                0, '0});
      directed_rows.push_back('{mk_req(FUNC_QUEUE_LOCK, LOCK_OTHER, 3'd2, 64'd0, 0, 0,
                                       32'hA5A5_A5A5, 0, 0), 0, '0});
      directed_rows.push_back('{mk_req(FUNC_HANDLE_LOCK, LOCK_OTHER, 3'd0, 64'd0, 0, 0, 0, 0, 0),
                                0, '0});
      directed_rows.push_back('{mk_req(FUNC_QUEUE_LOCK, LOCK_SPARE, 3'd3, 64'd0, 0, 0,
                                       32'h5A5A_5A5A, 0, 0), 0, '0});
      directed_rows.push_back('{mk_req(FUNC_HANDLE_EXC, EXC_OTHER, 3'd0, 64'd0, 0, 0, 0, 0, 0),
                                0, '0});
      // interlock slot was flushed by the exception handling above
      directed_rows.push_back('{mk_req(FUNC_HANDLE_LOCK, LOCK_OTHER, 3'd0, 64'd0, 0, 0, 0, 0, 0),
                                1, idle_rsp});

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part, light idling on both sides
      tx_idle_pct = 20;
      rx_idle_pct = 20;
      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].req);
         want = predict_fault_response(directed_rows[i].req);
         if (directed_rows[i].typed) want = directed_rows[i].rsp;
         expected_responses.push_back(want);
      end

      // random part: slow receiver, then slow sender, then full rate
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 32; rx_idle_pct = 88; end
            1: begin tx_idle_pct = 88; rx_idle_pct = 32; end
            default: begin
               tx_idle_pct   = 0;
               rx_idle_pct   = 0;
               want_hold_off = 1'b1;
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            req_payload_type r;
            r = random_fault_request();
            send_beat(r);
            expected_responses.push_back(predict_fault_response(r));
         end
         // sender pauses until the unit has drained after the first phase
         if (phase == 0) begin
            req_chan.valid <= 1'b0;
            while (expected_responses.size() != 0) @(posedge clock);
         end
      end
      req_chan.valid <= 1'b0;

      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== pipeline_fault_priority_unit.f =====
rtl/core/pfpu_pkg.sv
rtl/core/pfpu_req_if.sv
rtl/core/pfpu_rsp_if.sv
rtl/core/pfpu_slots.sv
rtl/core/pipeline_fault_priority_unit.sv
tb/tb_pipeline_fault_priority_unit.sv
